>>> hw/rtl/ll1p_pkg.sv
// ----------------------------------------------------------------------------
// ll1p_pkg
// Shared types and constants for the table-driven LL(1) parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ll1p_pkg;

  // default sizes
  localparam int DEF_STACK_DEPTH      = 256;
  localparam int DEF_NUM_NONTERMINALS = 32;
  localparam int DEF_NUM_TERMINALS    = 32;
  localparam int DEF_NUM_PRODUCTIONS  = 64;
  localparam int DEF_MAX_RHS          = 16;

  // register reset values
  localparam logic [4:0] RST_START_NT = 5'd0;
  localparam logic [4:0] RST_END_T    = 5'd17;
  localparam logic [7:0] RST_MAX_EXP  = 8'd64;

  // configuration register indexes
  localparam logic [1:0] CFG_START_NT = 2'd0;
  localparam logic [1:0] CFG_END_T    = 2'd1;
  localparam logic [1:0] CFG_MAX_EXP  = 2'd2;

  // symbol and table entry layout
  localparam int NT_BIT_POS    = 5;
  localparam int ENTRY_VLD_POS = 6;

  typedef enum logic [1:0] {
    MODE_LOAD_TBL = 2'd0,
    MODE_LOAD_RHS = 2'd1,
    MODE_START    = 2'd2,
    MODE_TOKEN    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_LOADED   = 3'd0,
    ST_CONSUMED = 3'd1,
    ST_ACCEPTED = 3'd2,
    ST_NO_ENTRY = 3'd3,
    ST_MISMATCH = 3'd4,
    ST_OVERFLOW = 3'd5,
    ST_IDLE     = 3'd6,
    ST_LIMIT    = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_CHECK,
    S_TBL,
    S_LEN,
    S_PUSH,
    S_POPB
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/ll1p_table.sv
// ----------------------------------------------------------------------------
// ll1p_table
// Parse table memory with a clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ll1p_table
  import ll1p_pkg::*;
#(
  parameter int DEPTH = DEF_NUM_NONTERMINALS * DEF_NUM_TERMINALS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [6:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [6:0]    rdata,
  output logic               clearing
);

  logic [6:0]    mem [DEPTH];
  logic          clearing_r;
  logic [AW-1:0] clr_addr_r;

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) clearing_r <= 1'b0;
    end
  end

  // write and registered read
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign clearing = clearing_r;

endmodule

`default_nettype wire

>>> hw/rtl/ll1p_rhs.sv
// ----------------------------------------------------------------------------
// ll1p_rhs
// Right-hand side symbol store and production length store.
// ----------------------------------------------------------------------------
`default_nettype none

module ll1p_rhs
  import ll1p_pkg::*;
#(
  parameter int SYM_DEPTH = DEF_NUM_PRODUCTIONS * DEF_MAX_RHS,
  parameter int SAW       = 10,
  parameter int LEN_DEPTH = DEF_NUM_PRODUCTIONS,
  parameter int LAW       = 6,
  parameter int LW        = 5
) (
  input  wire logic           clk,
  input  wire logic           sym_we,
  input  wire logic [SAW-1:0] sym_waddr,
  input  wire logic [5:0]     sym_wdata,
  input  wire logic [SAW-1:0] sym_raddr,
  output logic      [5:0]     sym_rdata,
  input  wire logic           len_we,
  input  wire logic [LAW-1:0] len_waddr,
  input  wire logic [LW-1:0]  len_wdata,
  input  wire logic [LAW-1:0] len_raddr,
  output logic      [LW-1:0]  len_rdata
);

  logic [5:0]    sym_mem [SYM_DEPTH];
  logic [LW-1:0] len_mem [LEN_DEPTH];

  // symbol store
  always_ff @(posedge clk) begin
    if (sym_we) sym_mem[sym_waddr] <= sym_wdata;
    sym_rdata <= sym_mem[sym_raddr];
  end

  // length store
  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_waddr] <= len_wdata;
    len_rdata <= len_mem[len_raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/ll1p_stack.sv
// ----------------------------------------------------------------------------
// ll1p_stack
// Parse stack memory, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ll1p_stack
  import ll1p_pkg::*;
#(
  parameter int DEPTH = DEF_STACK_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [5:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [5:0]    rdata
);

  logic [5:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/ll1_table_driven_parser.sv
// ----------------------------------------------------------------------------
// ll1_table_driven_parser
// Table-driven LL(1) predictive parser with load, start and token commands.
// ----------------------------------------------------------------------------
// Each command is taken when start is high and busy is low, and gives one
// result beat on the out_ ports for one cycle, flagged by out_valid; the
// receiver must take it then. Table and right-side loads, and tokens given
// while no parse is running, put their result on the ports in the cycle right
// after acceptance and keep busy low; a start is answered from S_START. A token
// runs a small sequencer over the stack, table and right-side memories: S_CHECK
// and S_POPB for the terminal check and pop, and per expansion S_CHECK, S_TBL,
// S_LEN and S_PUSH for each pushed symbol (S_POPB for an empty right side),
// since every lookup goes through one registered memory read; the result beat
// is registered from the token's last state. After reset the parse table is
// cleared one entry a cycle (NUM_NONTERMINALS * NUM_TERMINALS entries, 1024 by
// default) while busy stays high; configuration writes are taken at all times.
// ----------------------------------------------------------------------------
`default_nettype none

module ll1_table_driven_parser
  import ll1p_pkg::*;
#(
  parameter int STACK_DEPTH      = DEF_STACK_DEPTH,
  parameter int NUM_NONTERMINALS = DEF_NUM_NONTERMINALS,
  parameter int NUM_TERMINALS    = DEF_NUM_TERMINALS,
  parameter int NUM_PRODUCTIONS  = DEF_NUM_PRODUCTIONS,
  parameter int MAX_RHS          = DEF_MAX_RHS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_mode,
  input  wire logic [4:0] in_nonterminal_index,
  input  wire logic [4:0] in_terminal_index,
  input  wire logic [5:0] in_production_number,
  input  wire logic       in_entry_valid,
  input  wire logic [3:0] in_rhs_position,
  input  wire logic [5:0] in_rhs_symbol,
  input  wire logic [4:0] in_rhs_length,
  output logic            out_valid,
  output logic [2:0]      out_status,
  output logic [5:0]      out_top_symbol,
  output logic [7:0]      out_expansions_done,
  output logic [8:0]      out_stack_depth,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int TBL_DEPTH = NUM_NONTERMINALS * NUM_TERMINALS;
  localparam int TAW       = $clog2(TBL_DEPTH);
  localparam int SYM_DEPTH = NUM_PRODUCTIONS * MAX_RHS;
  localparam int RAW       = (SYM_DEPTH > 1) ? $clog2(SYM_DEPTH) : 1;
  localparam int PAW       = (NUM_PRODUCTIONS > 1) ? $clog2(NUM_PRODUCTIONS) : 1;
  localparam int LW        = $clog2(MAX_RHS + 1);
  localparam int SAW       = $clog2(STACK_DEPTH);
  localparam int CW        = $clog2(STACK_DEPTH + 1);

  // configuration registers
  logic [4:0] start_nt_r;
  logic [4:0] end_t_r;
  logic [7:0] max_exp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_nt_r <= RST_START_NT;
      end_t_r    <= RST_END_T;
      max_exp_r  <= RST_MAX_EXP;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_START_NT: start_nt_r <= cfg_data[4:0];
        CFG_END_T:    end_t_r    <= cfg_data[4:0];
        CFG_MAX_EXP:  max_exp_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // sequencer and datapath registers
  state_t         state_r, state_nxt;
  logic           phase_r, phase_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [5:0]     top_r, top_nxt;
  logic [4:0]     term_r, term_nxt;
  logic [7:0]     exps_r, exps_nxt;
  logic           tbl_ok_r, tbl_ok_nxt;
  logic [PAW-1:0] prod_r, prod_nxt;
  logic [LW-1:0]  k_r, k_nxt;
  logic           pop_match_r, pop_match_nxt;

  // result registers
  logic       out_valid_r;
  logic [2:0] out_status_r;
  logic [5:0] out_top_r;
  logic [7:0] out_exps_r;
  logic [8:0] out_depth_r;
  logic       emit;
  status_t    e_status;
  logic [5:0] e_top;
  logic [7:0] e_exps;

  // memory ports
  logic           tbl_we;
  logic [TAW-1:0] tbl_waddr, tbl_raddr;
  logic [6:0]     tbl_wdata, tbl_rdata;
  logic           clearing;
  logic           sym_we, len_we;
  logic [RAW-1:0] sym_waddr, sym_raddr;
  logic [5:0]     sym_rdata;
  logic [PAW-1:0] len_waddr, len_raddr;
  logic [LW-1:0]  len_wdata, len_rdata;
  logic           stk_we;
  logic [SAW-1:0] stk_waddr, stk_raddr;
  logic [5:0]     stk_wdata, stk_rdata;

  // shared decode
  logic       acc;
  logic [6:0] entry;
  logic       ent_bad, lim, ovf, match, cnt_zero, top_nt;
  logic [5:0] top_or_zero;

  assign busy        = clearing || (state_r != S_IDLE);
  assign acc         = start && !busy;
  assign cnt_zero    = (count_r == '0);
  assign top_nt      = top_r[NT_BIT_POS];
  assign match       = (top_r == {1'b0, term_r});
  assign entry       = tbl_ok_r ? tbl_rdata : 7'd0;
  assign ent_bad     = !entry[ENTRY_VLD_POS] || (32'(entry[5:0]) >= NUM_PRODUCTIONS);
  assign lim         = (exps_r >= max_exp_r);
  assign ovf         = (32'(count_r) - 32'd1 + 32'(len_rdata)) > 32'(STACK_DEPTH);
  assign top_or_zero = cnt_zero ? 6'd0 : top_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc && in_mode == MODE_START) state_nxt = S_START;
        else if (acc && in_mode == MODE_TOKEN && phase_r) state_nxt = S_CHECK;
      end
      S_START: state_nxt = S_IDLE;
      S_CHECK: begin
        if (cnt_zero) state_nxt = S_IDLE;
        else if (top_nt) state_nxt = S_TBL;
        else if (match) state_nxt = S_POPB;
        else state_nxt = S_IDLE;
      end
      S_TBL: state_nxt = (ent_bad || lim) ? S_IDLE : S_LEN;
      S_LEN: begin
        if (ovf) state_nxt = S_IDLE;
        else if (len_rdata == '0) state_nxt = S_POPB;
        else state_nxt = S_PUSH;
      end
      S_PUSH: state_nxt = (k_r > LW'(1)) ? S_PUSH : S_CHECK;
      S_POPB: state_nxt = pop_match_r ? S_IDLE : S_CHECK;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    top_nxt       = top_r;
    term_nxt      = term_r;
    exps_nxt      = exps_r;
    tbl_ok_nxt    = tbl_ok_r;
    prod_nxt      = prod_r;
    k_nxt         = k_r;
    pop_match_nxt = pop_match_r;
    emit          = 1'b0;
    e_status      = ST_LOADED;
    e_top         = top_or_zero;
    e_exps        = exps_r;
    tbl_we        = 1'b0;
    tbl_waddr     = TAW'(32'(in_nonterminal_index) * NUM_TERMINALS
                         + 32'(in_terminal_index));
    tbl_wdata     = in_entry_valid ? {1'b1, in_production_number} : 7'd0;
    tbl_raddr     = TAW'(32'(top_r[4:0]) * NUM_TERMINALS + 32'(term_r));
    sym_we        = 1'b0;
    sym_waddr     = RAW'(32'(in_production_number) * MAX_RHS + 32'(in_rhs_position));
    sym_raddr     = RAW'(32'(prod_r) * MAX_RHS + 32'(k_r) - 32'd2);
    len_we        = 1'b0;
    len_waddr     = PAW'(in_production_number);
    len_wdata     = (32'(in_rhs_length) > MAX_RHS) ? LW'(MAX_RHS) : LW'(in_rhs_length);
    len_raddr     = PAW'(entry[5:0]);
    stk_we        = 1'b0;
    stk_waddr     = SAW'(count_r);
    stk_wdata     = sym_rdata;
    stk_raddr     = SAW'(count_r - CW'(2));
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_mode)
            MODE_LOAD_TBL: begin
              tbl_we = (32'(in_nonterminal_index) < NUM_NONTERMINALS)
                    && (32'(in_terminal_index) < NUM_TERMINALS);
              emit   = 1'b1;
              e_exps = 8'd0;
            end
            MODE_LOAD_RHS: begin
              len_we = 32'(in_production_number) < NUM_PRODUCTIONS;
              sym_we = len_we && (32'(in_rhs_position) < MAX_RHS);
              emit   = 1'b1;
              e_exps = 8'd0;
            end
            MODE_START: begin
              stk_we    = 1'b1;
              stk_waddr = '0;
              stk_wdata = {1'b0, end_t_r};
            end
            default: begin
              if (phase_r) begin
                term_nxt = in_terminal_index;
                exps_nxt = 8'd0;
              end else begin
                emit     = 1'b1;
                e_status = ST_IDLE;
                e_exps   = 8'd0;
              end
            end
          endcase
        end
      end
      S_START: begin
        stk_we    = 1'b1;
        stk_waddr = SAW'(1);
        stk_wdata = {1'b1, start_nt_r};
        count_nxt = CW'(2);
        top_nxt   = {1'b1, start_nt_r};
        phase_nxt = 1'b1;
        emit      = 1'b1;
        e_top     = {1'b1, start_nt_r};
        e_exps    = 8'd0;
      end
      S_CHECK: begin
        if (cnt_zero) begin
          phase_nxt = 1'b0;
          emit      = 1'b1;
          e_status  = ST_MISMATCH;
          e_top     = 6'd0;
        end else if (top_nt) begin
          tbl_ok_nxt = (32'(top_r[4:0]) < NUM_NONTERMINALS)
                    && (32'(term_r) < NUM_TERMINALS);
        end else if (match) begin
          count_nxt     = count_r - 1'b1;
          pop_match_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          emit      = 1'b1;
          e_status  = ST_MISMATCH;
          e_top     = top_r;
        end
      end
      S_TBL: begin
        prod_nxt = PAW'(entry[5:0]);
        if (ent_bad || lim) begin
          phase_nxt = 1'b0;
          emit      = 1'b1;
          e_status  = ent_bad ? ST_NO_ENTRY : ST_LIMIT;
          e_top     = top_r;
        end
      end
      S_LEN: begin
        if (ovf) begin
          phase_nxt = 1'b0;
          emit      = 1'b1;
          e_status  = ST_OVERFLOW;
          e_top     = top_r;
        end else begin
          count_nxt = count_r - 1'b1;
          k_nxt     = len_rdata;
          sym_raddr = RAW'(32'(prod_r) * MAX_RHS + 32'(len_rdata) - 32'd1);
          if (len_rdata == '0) begin
            pop_match_nxt = 1'b0;
            exps_nxt      = exps_r + 1'b1;
          end
        end
      end
      S_PUSH: begin
        stk_we    = 1'b1;
        count_nxt = count_r + 1'b1;
        top_nxt   = sym_rdata;
        k_nxt     = k_r - 1'b1;
        if (k_r <= LW'(1)) exps_nxt = exps_r + 1'b1;
      end
      S_POPB: begin
        top_nxt = stk_rdata;
        if (pop_match_r) begin
          emit     = 1'b1;
          e_top    = cnt_zero ? 6'd0 : stk_rdata;
          e_status = (term_r == end_t_r) ? ST_ACCEPTED : ST_CONSUMED;
          if (term_r == end_t_r) phase_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      out_valid_r <= emit;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_r       <= top_nxt;
    term_r      <= term_nxt;
    exps_r      <= exps_nxt;
    tbl_ok_r    <= tbl_ok_nxt;
    prod_r      <= prod_nxt;
    k_r         <= k_nxt;
    pop_match_r <= pop_match_nxt;
    if (emit) begin
      out_status_r <= e_status;
      out_top_r    <= e_top;
      out_exps_r   <= e_exps;
      out_depth_r  <= 9'(count_nxt);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_top_symbol      = out_top_r;
  assign out_expansions_done = out_exps_r;
  assign out_stack_depth     = out_depth_r;

  // memories
  ll1p_table #(.DEPTH(TBL_DEPTH), .AW(TAW)) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .we       (tbl_we),
    .waddr    (tbl_waddr),
    .wdata    (tbl_wdata),
    .raddr    (tbl_raddr),
    .rdata    (tbl_rdata),
    .clearing (clearing)
  );

  ll1p_rhs #(
    .SYM_DEPTH (SYM_DEPTH),
    .SAW       (RAW),
    .LEN_DEPTH (NUM_PRODUCTIONS),
    .LAW       (PAW),
    .LW        (LW)
  ) u_rhs (
    .clk       (clk),
    .sym_we    (sym_we),
    .sym_waddr (sym_waddr),
    .sym_wdata (in_rhs_symbol),
    .sym_raddr (sym_raddr),
    .sym_rdata (sym_rdata),
    .len_we    (len_we),
    .len_waddr (len_waddr),
    .len_wdata (len_wdata),
    .len_raddr (len_raddr),
    .len_rdata (len_rdata)
  );

  ll1p_stack #(.DEPTH(STACK_DEPTH), .AW(SAW)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

endmodule

`default_nettype wire

>>> hw/rtl/ll1p_checker.sv
// ----------------------------------------------------------------------------
// ll1p_checker
// Port-level checks for the LL(1) parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ll1p_checker
  import ll1p_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] in_mode,
  input wire logic       out_valid,
  input wire logic [2:0] out_status,
  input wire logic [7:0] out_expansions_done,
  input wire logic [8:0] out_stack_depth
);

  // a result beat leaves the block ready for the next command
  a_ready_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy high during result beat");

  // loads answer in the next cycle with status loaded
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_mode == MODE_LOAD_TBL || in_mode == MODE_LOAD_RHS))
    |=> (out_valid && out_status == ST_LOADED))
    else $error("load command without loaded result");

  // a start leaves end marker and start symbol on the stack
  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_START)
    |=> ##1 (out_valid && out_status == ST_LOADED && out_stack_depth == 9'd2))
    else $error("start command result wrong");

  // idle tokens do no expansions
  a_idle_no_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_IDLE) |-> (out_expansions_done == 8'd0))
    else $error("idle result with expansions");

  // at each result beat the stack depth is within STACK_DEPTH
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_stack_depth) <= STACK_DEPTH))
    else $error("stack depth beyond limit");

endmodule

bind ll1_table_driven_parser ll1p_checker #(.STACK_DEPTH(STACK_DEPTH)) u_ll1p_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_mode             (in_mode),
  .out_valid           (out_valid),
  .out_status          (out_status),
  .out_expansions_done (out_expansions_done),
  .out_stack_depth     (out_stack_depth)
);

`default_nettype wire
